// ===== rtl/core/session_token_table_top_defines.svh =====
// Assertion macros for the session token table.
// Used by session_token_table_top; relies on clk_i and rst_ni in the including scope.
`ifndef SESSION_TOKEN_TABLE_TOP_DEFINES_SVH
`define SESSION_TOKEN_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define STT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define STT_ASSERT(name, prop, msg)
`define STT_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ===== rtl/core/stt_pkg.sv =====
// Shared types and constants for the session token table.
// No dependencies; imported by stt_slot_store and session_token_table_top.
package stt_pkg;

  localparam int SLOTS   = 8;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOKEN_W = 256;
  localparam int NOW_W   = 62;
  localparam int LIFE_W  = 40;
  localparam int EXP_W   = 63;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 40'd43200000000;

  typedef enum logic [1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_CHECK   = 2'd1,
    FUNC_DESTROY = 2'd2
  } stt_func_e;

  typedef struct packed {
    logic               set;
    logic               clr;
    logic [IDX_W-1:0]   idx;
    logic [TOKEN_W-1:0] token;
    logic [EXP_W-1:0]   expiry;
  } stt_wr_t;

  typedef struct packed {
    logic               used;
    logic [TOKEN_W-1:0] token;
    logic [EXP_W-1:0]   expiry;
  } stt_slot_t;

  function automatic logic [2:0] to_slot_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] ext;
    ext = {3'b000, idx};
    return ext[2:0];
  endfunction

endpackage

// ===== rtl/core/stt_slot_store.sv =====
// Slot storage: occupancy bits, tokens and expiry times, one read port.
// Depends on stt_pkg.
module stt_slot_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stt_pkg::stt_wr_t              wr_i,
  input  logic [stt_pkg::IDX_W-1:0]     rd_idx_i,
  output stt_pkg::stt_slot_t            rd_o
);
  import stt_pkg::*;

  logic [SLOTS-1:0]   used_q;
  logic [TOKEN_W-1:0] token_q  [SLOTS];
  logic [EXP_W-1:0]   expiry_q [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.set) begin
      used_q[wr_i.idx] <= 1'b1;
    end else if (wr_i.clr) begin
      used_q[wr_i.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      token_q[wr_i.idx]  <= wr_i.token;
      expiry_q[wr_i.idx] <= wr_i.expiry;
    end
  end

  assign rd_o.used   = used_q[rd_idx_i];
  assign rd_o.token  = token_q[rd_idx_i];
  assign rd_o.expiry = expiry_q[rd_idx_i];

endmodule

// ===== rtl/core/session_token_table_top.sv =====
// Top level of the session token table: request sequencer, shared comparator, output register.
// Depends on stt_pkg, stt_slot_store and session_token_table_top_defines.svh.
//
// A request is taken only while the sequencer is idle. It then walks the slots one per cycle
// through a single read port and one shared magnitude comparator. The result is loaded into the
// output register when the scan reaches a decision, at slot 0 at the earliest and at the last
// slot at the latest. The sequencer returns to idle as the result is loaded, so the next
// request can be accepted in the cycle after; no new request is taken while a scan runs. That
// request can be accepted while the previous result waits to be taken. If the output register
// still holds an untaken result when a scan ends, the sequencer waits until it is taken.
`include "session_token_table_top_defines.svh"

module session_token_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stt_pkg::LIFE_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [stt_pkg::NOW_W-1:0]     now_us_i,
  input  logic [63:0]                   token_w0_i,
  input  logic [63:0]                   token_w1_i,
  input  logic [63:0]                   token_w2_i,
  input  logic [63:0]                   token_w3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [2:0]                    slot_index_o
);
  import stt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   tgt_q, tgt_d;
  logic [EXP_W-1:0]   best_q, best_d;
  logic [LIFE_W-1:0]  lifetime_q;
  logic               out_valid_q;
  logic               hit_q;
  logic [2:0]         slot_index_q;
  logic               pend_hit_q;
  logic [IDX_W-1:0]   pend_idx_q;

  stt_func_e          func_q;
  logic [NOW_W-1:0]   now_q;
  logic [TOKEN_W-1:0] tok_q;
  logic [EXP_W-1:0]   new_exp_q;

  stt_wr_t            wr;
  stt_slot_t          slot;
  logic [EXP_W-1:0]   cmp_a, cmp_b;
  logic               cmp_lt;
  logic               tok_eq;
  logic               last;
  logic               take;
  logic               finish;
  logic               res_hit;
  logic [IDX_W-1:0]   res_idx;
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               load_hit;
  logic [IDX_W-1:0]   load_idx;

  stt_slot_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (idx_q),
    .rd_o     (slot)
  );

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = (idx_q == IDX_W'(SLOTS - 1));
  assign tok_eq   = (slot.token == tok_q);

  always_comb begin
    if (func_q == FUNC_CHECK) begin
      cmp_a = EXP_W'(now_q);
      cmp_b = slot.expiry;
    end else begin
      cmp_a = slot.expiry;
      cmp_b = best_q;
    end
  end

  assign cmp_lt = (cmp_a < cmp_b);
  assign take   = (idx_q == '0) || cmp_lt;

  always_comb begin
    wr        = '0;
    wr.token  = tok_q;
    wr.expiry = new_exp_q;
    finish    = 1'b0;
    res_hit   = 1'b0;
    res_idx   = '0;
    tgt_d     = tgt_q;
    best_d    = best_q;
    if (state_q == ST_SCAN) begin
      case (func_q)
        FUNC_CREATE: begin
          if (!slot.used) begin
            wr.set  = 1'b1;
            wr.idx  = idx_q;
            finish  = 1'b1;
            res_hit = 1'b1;
            res_idx = idx_q;
          end else begin
            if (take) begin
              tgt_d  = idx_q;
              best_d = slot.expiry;
            end
            if (last) begin
              wr.set  = 1'b1;
              wr.idx  = tgt_d;
              finish  = 1'b1;
              res_hit = 1'b1;
              res_idx = tgt_d;
            end
          end
        end
        FUNC_CHECK: begin
          if (slot.used && !cmp_lt) begin
            wr.clr = 1'b1;
            wr.idx = idx_q;
            finish = last;
          end else if (slot.used && tok_eq) begin
            finish  = 1'b1;
            res_hit = 1'b1;
            res_idx = idx_q;
          end else begin
            finish = last;
          end
        end
        FUNC_DESTROY: begin
          if (slot.used && tok_eq) begin
            wr.clr  = 1'b1;
            wr.idx  = idx_q;
            finish  = 1'b1;
            res_hit = 1'b1;
            res_idx = idx_q;
          end else begin
            finish = last;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    load_hit = res_hit;
    load_idx = res_idx;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        load_hit = pend_hit_q;
        load_idx = pend_idx_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      lifetime_q   <= LIFETIME_RESET;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      slot_index_q <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (cfg_we_i) begin
        lifetime_q <= cfg_wdata_i;
      end
      if (out_load) begin
        hit_q        <= load_hit;
        slot_index_q <= load_hit ? to_slot_index(load_idx) : 3'b000;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= stt_func_e'(func_i);
      now_q     <= now_us_i;
      tok_q     <= {token_w3_i, token_w2_i, token_w1_i, token_w0_i};
      new_exp_q <= EXP_W'(now_us_i) + EXP_W'(lifetime_q);
    end
    if (state_q == ST_SCAN) begin
      tgt_q  <= tgt_d;
      best_q <= best_d;
    end
    if (finish) begin
      pend_hit_q <= res_hit;
      pend_idx_q <= res_idx;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign slot_index_o = slot_index_q;

  `STT_ASSERT_NEXT(a_accept_starts_scan, accept, (state_q == ST_SCAN), "accepted request did not start a scan")
  `STT_ASSERT(a_set_clr_excl, !(wr.set && wr.clr), "slot written and cleared in the same cycle")
  `STT_ASSERT(a_load_when_free, (out_load |-> out_free), "result loaded over an unaccepted result")
  `STT_ASSERT_NEXT(a_create_hits, (out_load && (state_q == ST_SCAN) && (func_q == FUNC_CREATE)), hit_q, "create request finished without a hit")

endmodule
